/* design/pft_pkg.sv */
// Package for the physical frame table: field widths, table entry layout,
// request/result words and the controller/datapath command and status structs.
// No dependencies.
package pft_pkg;

	localparam int FRAME_COUNT   = 1024;
	localparam int PROCESS_COUNT = 64;

	localparam int FRAME_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int OWNER_W  = $clog2(PROCESS_COUNT + 1);
	localparam int INDEX_W  = 10;
	localparam int PID_W    = 6;
	localparam int PAGE_W   = 20;
	localparam int KIND_W   = 2;

	localparam logic [KIND_W-1:0] KIND_DIR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TBL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAGE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_MAP   = 2'd1,
		OP_FIND  = 2'd2,
		OP_FREE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               opcode;
		logic [INDEX_W-1:0] frame_index;
		logic [PID_W-1:0]   process_id;
		logic [PAGE_W-1:0]  virtual_page;
		logic [KIND_W-1:0]  frame_kind;
	} req_t;

	typedef struct packed {
		logic               status;
		logic [INDEX_W-1:0] frame_out;
		logic               enqueue_page;
		logic               clear_contents;
		logic               write_back;
		logic [PAGE_W-1:0]  write_back_page;
		logic [PID_W-1:0]   write_back_process;
	} res_t;

	typedef struct packed {
		logic               mapped;
		logic [OWNER_W-1:0] owner;
		logic [PAGE_W-1:0]  page;
		logic [KIND_W-1:0]  kind;
		logic               refcnt;
		logic               dirty;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		mapped: 1'b0,
		owner:  OWNER_W'(PROCESS_COUNT),
		page:   {PAGE_W{1'b1}},
		kind:   KIND_NONE,
		refcnt: 1'b0,
		dirty:  1'b1
	};

	typedef enum logic {
		ADDR_CNT = 1'b0,
		ADDR_REQ = 1'b1
	} addr_sel_t;

	typedef enum logic {
		WD_RESET = 1'b0,
		WD_MAP   = 1'b1
	} wd_sel_t;

	typedef enum logic [1:0] {
		RES_HIT  = 2'd0,
		RES_MISS = 2'd1,
		RES_MAP  = 2'd2,
		RES_FREE = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic      req_load;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      mem_re;
		logic      mem_we;
		addr_sel_t addr_sel;
		wd_sel_t   wd_sel;
		logic      res_load;
		res_sel_t  res_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
		logic idx_ok;
		logic free_ok;
		logic out_free;
		logic cnt_last;
	} stat_t;

endpackage

/* design/pft_req_if.sv */
// Request channel of the physical frame table: valid/ready plus one request word.
// Depends on pft_pkg.
interface pft_req_if;
	import pft_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/pft_res_if.sv */
// Result channel of the physical frame table: valid/ready plus one result word.
// Depends on pft_pkg.
interface pft_res_if;
	import pft_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/physical_frame_table.sv */
// Physical frame table, first-fit allocate and find over a single-port table.
// The next word is taken only after the last result moves into the output register,
// so one word in flight plus one waiting result.
// The scan reads one table entry per cycle through the memory's single port.
// After reset a clearing pass writes every entry, with ready low.
module physical_frame_table (
	input  logic      clk,
	input  logic      arst_n,
	pft_req_if.sink   req,
	pft_res_if.source res
);
	import pft_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.opcode   (req.data.opcode),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pft_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.stat     (stat),
		.res      (res)
	);

endmodule

/* design/pft_dp.sv */
// Datapath of the physical frame table: request register, frame table memory,
// scan counter, match logic, result register and output register.
// Depends on pft_pkg and pft_res_if.
module pft_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  pft_pkg::req_t  req_data,
	input  pft_pkg::cmd_t  cmd,
	output pft_pkg::stat_t stat,
	pft_res_if.source      res
);
	import pft_pkg::*;

	entry_t mem [FRAME_COUNT];

	req_t               req_q;
	logic [FRAME_W-1:0] cnt_q;
	logic [FRAME_W-1:0] addr;
	entry_t             wdata;
	entry_t             rdata_s1;
	logic [FRAME_W-1:0] addr_s1;
	logic               rvalid_s1;
	logic               scan_match;
	res_t               res_d;
	res_t               res_q;
	res_t               out_q;
	logic               out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.req_load)
			req_q <= req_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		addr = (cmd.addr_sel == ADDR_CNT) ? cnt_q : FRAME_W'(req_q.frame_index);
		if (cmd.wd_sel == WD_RESET) begin
			wdata = ENTRY_RESET;
		end else begin
			wdata.mapped = 1'b1;
			wdata.owner  = OWNER_W'(req_q.process_id);
			wdata.page   = req_q.virtual_page;
			wdata.kind   = req_q.frame_kind;
			wdata.refcnt = 1'b1;
			wdata.dirty  = 1'b0;
		end
	end

	// single-port table, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			mem[addr] <= wdata;
		else if (cmd.mem_re)
			rdata_s1 <= mem[addr];
		addr_s1 <= addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.mem_re && !cmd.mem_we;
		end
	end

	always_comb begin
		if (req_q.opcode == OP_ALLOC)
			scan_match = !rdata_s1.mapped;
		else
			scan_match = rdata_s1.mapped
				&& (32'(rdata_s1.owner) == 32'(req_q.process_id))
				&& (rdata_s1.kind == req_q.frame_kind)
				&& (rdata_s1.page == req_q.virtual_page);

		stat.hit      = rvalid_s1 && scan_match;
		stat.last     = rvalid_s1 && (addr_s1 == FRAME_W'(FRAME_COUNT - 1));
		stat.idx_ok   = 32'(req_q.frame_index) < FRAME_COUNT;
		stat.free_ok  = stat.idx_ok && (rdata_s1.kind != KIND_NONE);
		stat.out_free = !out_valid_q || res.ready;
		stat.cnt_last = cnt_q == FRAME_W'(FRAME_COUNT - 1);
	end

	always_comb begin
		res_d = '0;
		unique case (cmd.res_sel)
			RES_HIT: begin
				res_d.status    = STATUS_OK;
				res_d.frame_out = INDEX_W'(addr_s1);
			end
			RES_MISS: begin
				res_d.status = STATUS_ERR;
			end
			RES_MAP: begin
				res_d.status       = stat.idx_ok ? STATUS_OK : STATUS_ERR;
				res_d.enqueue_page = stat.idx_ok && (req_q.frame_kind == KIND_PAGE);
			end
			RES_FREE: begin
				res_d.status         = stat.free_ok ? STATUS_OK : STATUS_ERR;
				res_d.clear_contents = stat.free_ok;
				if (stat.free_ok && (rdata_s1.kind == KIND_PAGE)) begin
					res_d.write_back         = 1'b1;
					res_d.write_back_page    = rdata_s1.page;
					res_d.write_back_process = req_q.process_id;
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load)
			res_q <= res_d;
		if (cmd.out_load)
			out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

endmodule

/* design/pft_ctrl.sv */
// Controller of the physical frame table: clearing pass, request dispatch,
// table scan sequencing and result hand-off.
// Depends on pft_pkg.
module pft_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  pft_pkg::op_t   opcode,
	output logic           in_ready,
	input  pft_pkg::stat_t stat,
	output pft_pkg::cmd_t  cmd
);
	import pft_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MAP,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.mem_we   = 1'b1;
				cmd.addr_sel = ADDR_CNT;
				cmd.wd_sel   = WD_RESET;
				cmd.cnt_inc  = 1'b1;
				if (stat.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.cnt_clr = 1'b1;
				if (in_valid) begin
					cmd.req_load = 1'b1;
					unique case (opcode)
						OP_ALLOC, OP_FIND: state_d = ST_SCAN;
						OP_MAP:            state_d = ST_MAP;
						OP_FREE:           state_d = ST_FREE_RD;
						default:           state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.mem_re   = 1'b1;
				cmd.addr_sel = ADDR_CNT;
				cmd.cnt_inc  = !stat.cnt_last;
				priority if (stat.hit) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_HIT;
					state_d      = ST_FINISH;
				end else if (stat.last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_MISS;
					state_d      = ST_FINISH;
				end
			end
			ST_MAP: begin
				cmd.mem_we   = stat.idx_ok;
				cmd.addr_sel = ADDR_REQ;
				cmd.wd_sel   = WD_MAP;
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_MAP;
				state_d      = ST_FINISH;
			end
			ST_FREE_RD: begin
				cmd.mem_re   = stat.idx_ok;
				cmd.addr_sel = ADDR_REQ;
				state_d      = ST_FREE_CHK;
			end
			ST_FREE_CHK: begin
				cmd.mem_we   = stat.free_ok;
				cmd.addr_sel = ADDR_REQ;
				cmd.wd_sel   = WD_RESET;
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_FREE;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result moved into a busy output register");

	a_req_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mem_we && (cmd.addr_sel == ADDR_REQ)) |-> stat.idx_ok)
		else $error("table write at a frame index out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in progress");

	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && stat.hit) |=> (state_q == ST_FINISH) && !in_ready)
		else $error("scan hit did not end the scan");

endmodule

/* tb/sv/testbench.sv */
// Testbench for physical_frame_table: random and directed requests against an
// in-bench model of the frame table, results checked word by word in order.
// Depends on pft_pkg, pft_req_if, pft_res_if and the physical_frame_table RTL.
module testbench;
	import pft_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pft_req_if req();
	pft_res_if res();

	physical_frame_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	req_t        request_q[$];
	req_t        map_history[$];
	res_t        expected_q[$];
	entry_t      frame_entries[FRAME_COUNT];
	int unsigned words_issued = 0;
	int unsigned words_taken = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	logic [15:0] stall_cycle = '0;

	// Model of the table: applies one request and returns its result word.
	function automatic res_t frame_table_answer(input req_t r);
		res_t ans;
		int   f;
		ans = '0;
		ans.status = STATUS_ERR;
		case (r.opcode)
		OP_ALLOC: begin
			for (f = 0; f < FRAME_COUNT; f++) begin
				if (!frame_entries[f].mapped) begin
					ans.status = STATUS_OK;
					ans.frame_out = INDEX_W'(f);
					break;
				end
			end
		end
		OP_MAP: begin
			if (int'(r.frame_index) < FRAME_COUNT) begin
				frame_entries[r.frame_index] = '{
					mapped: 1'b1,
					owner:  OWNER_W'(r.process_id),
					page:   r.virtual_page,
					kind:   r.frame_kind,
					refcnt: 1'b1,
					dirty:  1'b0
				};
				ans.status = STATUS_OK;
				ans.enqueue_page = (r.frame_kind == KIND_PAGE);
			end
		end
		OP_FIND: begin
			for (f = 0; f < FRAME_COUNT; f++) begin
				if (frame_entries[f].mapped &&
				    frame_entries[f].owner == OWNER_W'(r.process_id) &&
				    frame_entries[f].kind == r.frame_kind &&
				    frame_entries[f].page == r.virtual_page) begin
					ans.status = STATUS_OK;
					ans.frame_out = INDEX_W'(f);
					break;
				end
			end
		end
		OP_FREE: begin
			// untyped frames refuse the free whether mapped or not
			if (int'(r.frame_index) < FRAME_COUNT &&
			    frame_entries[r.frame_index].kind != KIND_NONE) begin
				ans.status = STATUS_OK;
				ans.clear_contents = 1'b1;
				if (frame_entries[r.frame_index].kind == KIND_PAGE) begin
					ans.write_back = 1'b1;
					ans.write_back_page = frame_entries[r.frame_index].page;
					ans.write_back_process = r.process_id;
				end
				frame_entries[r.frame_index] = ENTRY_RESET;
			end
		end
		endcase
		return ans;
	endfunction

	task automatic queue_request(input op_t op, input int idx, input int pid,
	                             input int vpn, input logic [KIND_W-1:0] kind);
		req_t r;
		r.opcode = op;
		r.frame_index = INDEX_W'(idx);
		r.process_id = PID_W'(pid);
		r.virtual_page = PAGE_W'(vpn);
		r.frame_kind = kind;
		request_q.push_back(r);
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatch_count++;
		end
	endtask

	// most traffic stays in a small window so allocate scans stay short
	function automatic int pick_frame();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, FRAME_COUNT - 1)
		                                   : $urandom_range(0, 31);
	endfunction

	function automatic int pick_page();
		case ($urandom_range(0, 9))
		0: return 0;
		1: return 20'hFFFFF;
		default: return $urandom_range(0, 20'hFFFFF);
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		return ($urandom_range(0, 9) == 0) ? KIND_NONE : KIND_W'($urandom_range(0, 2));
	endfunction

	// sender: bursts of words with random gaps in between
	always @(negedge clk) begin
		if (arst_n === 1'b1 && (!req.valid || words_taken == words_issued)) begin
			if (gap_left > 0) begin
				req.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (request_q.size() > 0) begin
				req.valid <= 1'b1;
				req.data <= request_q.pop_front();
				words_issued++;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver: rotating stall pattern, plus two long hold-offs to back up the input
	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && results_seen >= 150) ||
		             (holds_done == 1 && results_seen >= 450)) begin
			res.ready <= 1'b0;
			hold_left <= 400;
			holds_done <= holds_done + 1;
		end else begin
			stall_cycle <= stall_cycle + 1'b1;
			case (stall_cycle[8:7])
			2'd1: res.ready <= ($urandom_range(0, 1) == 0);
			2'd2: res.ready <= ($urandom_range(0, 3) == 0);
			default: res.ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n === 1'b1) begin
			if (req.valid && req.ready) begin
				expected_q.push_back(frame_table_answer(req.data));
				words_taken++;
			end
			if (res.valid && res.ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: 0x%0h", res.data);
					mismatch_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("status", 32'(want.status), 32'(res.data.status));
					check_field("frame_out", 32'(want.frame_out),
					            32'(res.data.frame_out));
					check_field("enqueue_page", 32'(want.enqueue_page),
					            32'(res.data.enqueue_page));
					check_field("clear_contents", 32'(want.clear_contents),
					            32'(res.data.clear_contents));
					check_field("write_back", 32'(want.write_back),
					            32'(res.data.write_back));
					check_field("write_back_page", 32'(want.write_back_page),
					            32'(res.data.write_back_page));
					check_field("write_back_process", 32'(want.write_back_process),
					            32'(res.data.write_back_process));
				end
			end
		end
	end

	initial begin
		req_t h;
		int   n;
		int   sel;
		for (n = 0; n < FRAME_COUNT; n++) begin
			frame_entries[n] = ENTRY_RESET;
		end
		req.valid = 1'b0;
		req.data = '0;
		res.ready = 1'b0;

		// directed: empty table, extremes, remap, untyped frames
		queue_request(OP_ALLOC, 1023, 63, 20'hFFFFF, KIND_NONE);
		queue_request(OP_FIND, 0, 0, 0, KIND_DIR);
		queue_request(OP_FREE, 5, 7, 0, KIND_DIR);
		queue_request(OP_MAP, 0, 63, 20'hFFFFF, KIND_PAGE);
		queue_request(OP_MAP, 1023, 0, 0, KIND_DIR);
		queue_request(OP_MAP, 1, 1, 20'h12345, KIND_TBL);
		queue_request(OP_MAP, 2, 2, 20'hABCDE, KIND_NONE);
		queue_request(OP_ALLOC, 0, 0, 0, KIND_DIR);
		queue_request(OP_FIND, 512, 63, 20'hFFFFF, KIND_PAGE);
		queue_request(OP_FIND, 0, 0, 0, KIND_DIR);
		queue_request(OP_FIND, 0, 2, 20'hABCDE, KIND_NONE);
		queue_request(OP_FIND, 0, 1, 20'h12345, KIND_DIR);
		queue_request(OP_MAP, 1, 5, 7, KIND_PAGE);
		queue_request(OP_FIND, 0, 1, 20'h12345, KIND_TBL);
		queue_request(OP_FREE, 2, 4, 0, KIND_PAGE);
		queue_request(OP_FREE, 0, 42, 0, KIND_DIR);
		queue_request(OP_FREE, 1023, 3, 20'hFFFFF, KIND_PAGE);
		queue_request(OP_ALLOC, 0, 0, 0, KIND_DIR);
		queue_request(OP_FREE, 0, 1, 0, KIND_DIR);
		queue_request(OP_FREE, 1, 63, 0, KIND_DIR);
		queue_request(OP_MAP, 2, 9, 3, KIND_DIR);
		queue_request(OP_FREE, 2, 0, 20'hFFFFF, KIND_NONE);

		// random traffic; finds and frees mostly aim at frames mapped earlier
		for (n = 0; n < 560; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				queue_request(OP_ALLOC, $urandom_range(0, 1023), $urandom_range(0, 63),
				              pick_page(), pick_kind());
			end else if (sel < 55) begin
				queue_request(OP_MAP, pick_frame(),
				              ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3)
				                                          : $urandom_range(0, 63),
				              pick_page(), pick_kind());
				map_history.push_back(request_q[$]);
				if (map_history.size() > 64) begin
					void'(map_history.pop_front());
				end
			end else if (sel < 80) begin
				if (map_history.size() > 0 && $urandom_range(0, 3) != 0) begin
					h = map_history[$urandom_range(0, map_history.size() - 1)];
					queue_request(OP_FIND, pick_frame(), int'(h.process_id),
					              int'(h.virtual_page), h.frame_kind);
				end else begin
					queue_request(OP_FIND, pick_frame(), $urandom_range(0, 63),
					              pick_page(), pick_kind());
				end
			end else begin
				if (map_history.size() > 0 && $urandom_range(0, 9) < 7) begin
					h = map_history[$urandom_range(0, map_history.size() - 1)];
					queue_request(OP_FREE, int'(h.frame_index), $urandom_range(0, 63),
					              pick_page(), pick_kind());
				end else begin
					queue_request(OP_FREE, pick_frame(), $urandom_range(0, 63),
					              pick_page(), pick_kind());
				end
			end
		end

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		wait (request_q.size() == 0 && words_taken == words_issued &&
		      expected_q.size() == 0);
		repeat (FRAME_COUNT + 8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#80_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
